// ----- design/lzfbd_pkg.sv -----
`timescale 1ns / 1ps
package lzfbd_pkg;
    localparam int WindowBytesDef    = 65536;
    localparam int BytesPerResultDef = 8;
    localparam int LzMinMatch        = 4;
    localparam int FlagBits          = 8;

    localparam logic [2:0] ST_DATA    = 3'd0;
    localparam logic [2:0] ST_DONE    = 3'd1;
    localparam logic [2:0] ST_TRUNC   = 3'd2;
    localparam logic [2:0] ST_BADDIST = 3'd3;
    localparam logic [2:0] ST_OVERRUN = 3'd4;

    typedef struct packed {
        logic [7:0] stream_byte;
        logic       stream_end;
    } t_in_word;

    typedef struct packed {
        logic [63:0] out_bytes;
        logic [3:0]  byte_count;
        logic [2:0]  status;
        logic        run_last;
    } t_out_word;

    typedef struct packed {
        logic       load_in;
        logic       set_flag;
        logic       store_tok;
        logic       start_match;
        logic       put_lit;
        logic       rd;
        logic       put_copy;
        logic       flush;
        logic       emit_stat;
        logic [2:0] stat_code;
        logic       run_last;
        logic       set_fin;
        logic       restart;
    } t_cmd;

    typedef struct packed {
        logic       fin;
        logic       reached;
        logic       flag_empty;
        logic       tok_match;
        logic [1:0] phase;
        logic       bad_dist;
        logic       overrun;
        logic       last;
        logic       cnt_one;
        logic       pack_full_next;
        logic       out_free;
    } t_sts;
endpackage

// ----- design/lzfbd_ctrl.sv -----
`timescale 1ns / 1ps
module lzfbd_ctrl (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_in_valid,
    output logic            o_in_stall,
    input  lzfbd_pkg::t_sts i_sts,
    output lzfbd_pkg::t_cmd o_cmd
);
    import lzfbd_pkg::*;

    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_EVAL  = 4'd1;
    localparam logic [3:0] S_RD    = 4'd2;
    localparam logic [3:0] S_WR    = 4'd3;
    localparam logic [3:0] S_FLUSH = 4'd4;
    localparam logic [3:0] S_POST  = 4'd5;
    localparam logic [3:0] S_STAT  = 4'd6;
    localparam logic [3:0] S_END   = 4'd7;

    logic [3:0] r_state, n_state;
    logic [2:0] r_code, n_code;
    logic       r_more, n_more;

    assign o_in_stall = (r_state != S_IDLE);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_code  <= ST_DATA;
            r_more  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_code  <= n_code;
            r_more  <= n_more;
        end
    end

    always_comb begin
        n_state = r_state;
        n_code  = r_code;
        n_more  = r_more;
        o_cmd   = '0;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.load_in = 1'b1;
                    n_state = S_EVAL;
                end
            end
            S_EVAL: begin
                if (i_sts.fin) begin
                    n_state = S_END;
                end else if (i_sts.reached) begin
                    n_code  = ST_DONE;
                    n_state = S_STAT;
                end else if (i_sts.flag_empty) begin
                    o_cmd.set_flag = 1'b1;
                    n_state = S_POST;
                end else if (i_sts.tok_match) begin
                    if (i_sts.phase != 2'd2) begin
                        o_cmd.store_tok = 1'b1;
                        n_state = S_POST;
                    end else begin
                        o_cmd.start_match = 1'b1;
                        if (i_sts.bad_dist) begin
                            n_code  = ST_BADDIST;
                            n_state = S_STAT;
                        end else if (i_sts.overrun) begin
                            n_code  = ST_OVERRUN;
                            n_state = S_STAT;
                        end else begin
                            n_state = S_RD;
                        end
                    end
                end else begin
                    o_cmd.put_lit = 1'b1;
                    n_more  = 1'b0;
                    n_state = S_FLUSH;
                end
            end
            S_RD: begin
                o_cmd.rd = 1'b1;
                n_state = S_WR;
            end
            S_WR: begin
                o_cmd.put_copy = 1'b1;
                n_more = !i_sts.cnt_one;
                if (i_sts.cnt_one || i_sts.pack_full_next) begin
                    n_state = S_FLUSH;
                end else begin
                    n_state = S_RD;
                end
            end
            S_FLUSH: begin
                if (i_sts.out_free) begin
                    o_cmd.flush    = 1'b1;
                    o_cmd.run_last = !r_more && !i_sts.reached && !i_sts.last;
                    n_state = r_more ? S_RD : S_POST;
                end
            end
            S_POST: begin
                if (i_sts.reached) begin
                    n_code  = ST_DONE;
                    n_state = S_STAT;
                end else if (i_sts.last) begin
                    n_code  = ST_TRUNC;
                    n_state = S_STAT;
                end else begin
                    n_state = S_END;
                end
            end
            S_STAT: begin
                if (i_sts.out_free) begin
                    o_cmd.emit_stat = 1'b1;
                    o_cmd.stat_code = r_code;
                    o_cmd.run_last  = 1'b1;
                    o_cmd.set_fin   = 1'b1;
                    n_state = S_END;
                end
            end
            S_END: begin
                o_cmd.restart = i_sts.last;
                n_state = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end
endmodule

// ----- design/lzfbd_dp.sv -----
`timescale 1ns / 1ps
module lzfbd_dp #(
    parameter int WINDOW_BYTES     = lzfbd_pkg::WindowBytesDef,
    parameter int BYTES_PER_RESULT = lzfbd_pkg::BytesPerResultDef
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_we,
    input  logic [31:0]          i_cfg_wdata,
    input  lzfbd_pkg::t_in_word  i_in_word,
    input  lzfbd_pkg::t_cmd      i_cmd,
    output lzfbd_pkg::t_sts      o_sts,
    output logic                 o_out_valid,
    input  logic                 i_out_stall,
    output lzfbd_pkg::t_out_word o_out_word
);
    import lzfbd_pkg::*;

    localparam int AW     = $clog2(WINDOW_BYTES);
    localparam int PACK_W = 8 * BYTES_PER_RESULT;
    localparam int PCW    = $clog2(BYTES_PER_RESULT + 1);

    logic [7:0]        r_mem [WINDOW_BYTES];
    logic [7:0]        r_rdata;
    logic [7:0]        r_byte;
    logic              r_last;
    logic [31:0]       r_exp;
    logic [31:0]       r_produced;
    logic [7:0]        r_flag_word;
    logic [3:0]        r_flag_idx;
    logic [1:0]        r_phase;
    logic [7:0]        r_dlo, r_dhi;
    logic              r_fin;
    logic [AW-1:0]     r_wptr;
    logic [8:0]        r_cnt;
    logic [PACK_W-1:0] r_pack;
    logic [PCW-1:0]    r_pcnt;
    logic              r_out_valid;
    t_out_word         r_out_word;

    logic [16:0]       match_dist;
    logic [17:0]       rd_full;
    logic [AW-1:0]     rd_addr;
    logic [AW-1:0]     wptr_inc;
    logic              put;
    logic [7:0]        put_byte;
    logic [PACK_W-1:0] pack_add;

    assign match_dist = {1'b0, r_dhi, r_dlo} + 17'd1;
    assign rd_full = 18'(r_wptr) - 18'(match_dist);
    assign rd_addr = rd_full[17] ? AW'(rd_full + 18'(WINDOW_BYTES)) : AW'(rd_full);
    assign wptr_inc = (r_wptr == AW'(WINDOW_BYTES - 1)) ? '0 : r_wptr + AW'(1);
    assign put      = i_cmd.put_lit || i_cmd.put_copy;
    assign put_byte = i_cmd.put_copy ? r_rdata : r_byte;

    always_comb begin
        pack_add = r_pack;
        for (int i = 0; i < BYTES_PER_RESULT; i++) begin
            if (r_pcnt == PCW'(i)) begin
                pack_add[8*i +: 8] = put_byte;
            end
        end
    end

    always_comb begin
        o_sts.fin            = r_fin;
        o_sts.reached        = (r_produced >= r_exp);
        o_sts.flag_empty     = (r_flag_idx >= 4'(FlagBits));
        o_sts.tok_match      = r_flag_word[r_flag_idx[2:0]];
        o_sts.phase          = r_phase;
        o_sts.bad_dist       = (32'(match_dist) > r_produced)
                               || (match_dist > 17'(WINDOW_BYTES));
        o_sts.overrun        = ({1'b0, r_produced} + 33'(r_byte) + 33'(LzMinMatch))
                               > {1'b0, r_exp};
        o_sts.last           = r_last;
        o_sts.cnt_one        = (r_cnt == 9'd1);
        o_sts.pack_full_next = (r_pcnt == PCW'(BYTES_PER_RESULT - 1));
        o_sts.out_free       = !r_out_valid || !i_out_stall;
    end

    always_ff @(posedge i_clk) begin
        if (put) begin
            r_mem[r_wptr] <= put_byte;
        end
        if (i_cmd.rd) begin
            r_rdata <= r_mem[rd_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_in) begin
            r_byte <= i_in_word.stream_byte;
            r_last <= i_in_word.stream_end;
        end
        if (i_cmd.emit_stat) begin
            r_out_word <= '{out_bytes: '0, byte_count: '0,
                            status: i_cmd.stat_code, run_last: i_cmd.run_last};
        end else if (i_cmd.flush) begin
            r_out_word <= '{out_bytes: 64'(r_pack), byte_count: 4'(r_pcnt),
                            status: ST_DATA, run_last: i_cmd.run_last};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_exp       <= '0;
            r_produced  <= '0;
            r_flag_word <= '0;
            r_flag_idx  <= 4'(FlagBits);
            r_phase     <= '0;
            r_dlo       <= '0;
            r_dhi       <= '0;
            r_fin       <= 1'b0;
            r_wptr      <= '0;
            r_cnt       <= '0;
            r_pack      <= '0;
            r_pcnt      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_exp <= i_cfg_wdata;
            end
            if (i_cmd.flush || i_cmd.emit_stat) begin
                r_out_valid <= 1'b1;
            end else if (r_out_valid && !i_out_stall) begin
                r_out_valid <= 1'b0;
            end
            if (i_cmd.flush) begin
                r_pack <= '0;
                r_pcnt <= '0;
            end
            if (i_cmd.set_flag) begin
                r_flag_word <= r_byte;
                r_flag_idx  <= '0;
            end
            if (i_cmd.store_tok) begin
                if (r_phase == 2'd0) begin
                    r_dlo <= r_byte;
                end else begin
                    r_dhi <= r_byte;
                end
                r_phase <= r_phase + 2'd1;
            end
            if (i_cmd.start_match) begin
                r_flag_idx <= r_flag_idx + 4'd1;
                r_phase    <= '0;
                r_cnt      <= 9'(r_byte) + 9'(LzMinMatch);
            end
            if (i_cmd.put_lit) begin
                r_flag_idx <= r_flag_idx + 4'd1;
            end
            if (i_cmd.put_copy) begin
                r_cnt <= r_cnt - 9'd1;
            end
            if (put) begin
                r_produced <= r_produced + 32'd1;
                r_wptr     <= wptr_inc;
                r_pack     <= pack_add;
                r_pcnt     <= r_pcnt + PCW'(1);
            end
            if (i_cmd.set_fin) begin
                r_fin <= 1'b1;
            end
            if (i_cmd.restart) begin
                r_produced  <= '0;
                r_flag_word <= '0;
                r_flag_idx  <= 4'(FlagBits);
                r_phase     <= '0;
                r_dlo       <= '0;
                r_dhi       <= '0;
                r_fin       <= 1'b0;
                r_wptr      <= '0;
            end
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_word  = r_out_word;

    a_pack_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pcnt <= PCW'(BYTES_PER_RESULT))
        else $error("pack count past result width");
    a_emit_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.flush || i_cmd.emit_stat) |-> (!r_out_valid || !i_out_stall))
        else $error("result loaded over a held word");
    a_stat_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out_word.status != ST_DATA) |-> (r_out_word.byte_count == 4'd0))
        else $error("status word carries bytes");
    a_flush_nonempty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.flush |-> (r_pcnt != '0))
        else $error("empty data word");
endmodule

// ----- design/lzss_flag_byte_decompressor_top.sv -----
`timescale 1ns / 1ps
// LZSS flag-byte decompressor: one compressed byte is taken per word on the input channel;
// the next byte is stalled until this one has been handled. A match copies each byte by a
// history read then a write to the history memory, and sends a data word when the word fills
// or the match ends; it waits while the output word is held. Data words carry up to
// BYTES_PER_RESULT bytes; done or error words follow. History is not cleared: no clearing
// pass runs after reset, and the block accepts input at once.
module lzss_flag_byte_decompressor_top #(
    parameter int WINDOW_BYTES     = lzfbd_pkg::WindowBytesDef,
    parameter int BYTES_PER_RESULT = lzfbd_pkg::BytesPerResultDef
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_we,
    input  logic [31:0]          i_cfg_wdata,
    input  logic                 i_in_valid,
    output logic                 o_in_stall,
    input  lzfbd_pkg::t_in_word  i_in_word,
    output logic                 o_out_valid,
    input  logic                 i_out_stall,
    output lzfbd_pkg::t_out_word o_out_word
);
    import lzfbd_pkg::*;

    t_cmd cmd;
    t_sts sts;

    lzfbd_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_sts      (sts),
        .o_cmd      (cmd)
    );

    lzfbd_dp #(
        .WINDOW_BYTES     (WINDOW_BYTES),
        .BYTES_PER_RESULT (BYTES_PER_RESULT)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_in_word   (i_in_word),
        .i_cmd       (cmd),
        .o_sts       (sts),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_word  (o_out_word)
    );
endmodule

// ----- test/lzss_flag_byte_decompressor_top_tb.sv -----
`timescale 1ns / 1ps
module lzss_flag_byte_decompressor_top_tb;
    import lzfbd_pkg::*;

    localparam int PlanRows  = 37;
    localparam int IdleLimit = 20000;
    localparam int SettleCyc = 700;

    typedef struct {
        bit          cfg;
        logic [31:0] val;
        logic [7:0]  b;
        bit          e;
        bit          typed;
        logic [2:0]  st;
    } t_row;

    typedef struct {
        t_in_word   w;
        bit         typed;
        logic [2:0] st;
    } t_feed;

    logic      i_clk = 0;
    logic      i_rst_n = 0;
    logic      i_cfg_we = 0;
    logic [31:0] i_cfg_wdata = '0;
    logic      i_in_valid = 0;
    logic      o_in_stall;
    t_in_word  i_in_word = '0;
    logic      o_out_valid;
    logic      i_out_stall = 0;
    t_out_word o_out_word;

    lzss_flag_byte_decompressor_top u_top (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_word   (i_in_word),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_word  (o_out_word)
    );

    always #2 i_clk = ~i_clk;

    // decoder model state
    logic [7:0]  hist [0:65535];
    logic [31:0] want_len = 0;
    logic [31:0] made = 0;
    logic [7:0]  flags = 0;
    int          flag_ix = 8;
    int          phase = 0;
    logic [7:0]  d_lo = 0;
    logic [7:0]  d_hi = 0;
    bit          fin = 0;
    logic [63:0] pend;
    int          pcnt;

    t_out_word step_q[$];
    t_out_word decoded_q[$];
    t_feed     feed_q[$];
    t_row      plan [0:PlanRows-1];

    int errors = 0;
    int words_in = 0;
    int words_out = 0;
    int streams = 0;
    int idle_cyc = 0;

    function automatic t_out_word mk_word(logic [63:0] b, logic [3:0] n, logic [2:0] st);
        t_out_word r;
        r.out_bytes = b;
        r.byte_count = n;
        r.status = st;
        r.run_last = 1'b0;
        return r;
    endfunction

    task automatic flush_pend;
        if (pcnt > 0) begin
            step_q.push_back(mk_word(pend, 4'(pcnt), ST_DATA));
            pend = '0;
            pcnt = 0;
        end
    endtask

    task automatic put_byte(logic [7:0] v);
        hist[made[15:0]] = v;
        made = made + 1;
        pend[8*pcnt +: 8] = v;
        pcnt++;
        if (pcnt >= BytesPerResultDef) flush_pend();
    endtask

    task automatic decode_byte(t_in_word w);
        int unsigned span;
        int unsigned len;
        bit failed;
        step_q.delete();
        pend = '0;
        pcnt = 0;
        failed = 0;
        if (!fin) begin
            if (made >= want_len) begin
                step_q.push_back(mk_word('0, '0, ST_DONE));
                fin = 1;
            end else begin
                if (flag_ix >= FlagBits) begin
                    flags = w.stream_byte;
                    flag_ix = 0;
                end else if (flags[flag_ix]) begin
                    if (phase == 0) begin
                        d_lo = w.stream_byte;
                        phase = 1;
                    end else if (phase == 1) begin
                        d_hi = w.stream_byte;
                        phase = 2;
                    end else begin
                        span = {d_hi, d_lo} + 1;
                        len = w.stream_byte + LzMinMatch;
                        phase = 0;
                        flag_ix++;
                        if (span > made) begin
                            step_q.push_back(mk_word('0, '0, ST_BADDIST));
                            failed = 1;
                        end else if (64'(made) + 64'(len) > 64'(want_len)) begin
                            step_q.push_back(mk_word('0, '0, ST_OVERRUN));
                            failed = 1;
                        end else begin
                            for (int i = 0; i < len; i++) put_byte(hist[16'(made - span)]);
                            flush_pend();
                        end
                    end
                end else begin
                    flag_ix++;
                    put_byte(w.stream_byte);
                    flush_pend();
                end
                if (failed) begin
                    fin = 1;
                end else if (made >= want_len) begin
                    step_q.push_back(mk_word('0, '0, ST_DONE));
                    fin = 1;
                end else if (w.stream_end) begin
                    step_q.push_back(mk_word('0, '0, ST_TRUNC));
                    fin = 1;
                end
            end
        end
        if (w.stream_end) begin
            made = 0;
            flags = 0;
            flag_ix = 8;
            phase = 0;
            d_lo = 0;
            d_hi = 0;
            fin = 0;
            streams++;
        end
        if (step_q.size() > 0) step_q[step_q.size()-1].run_last = 1'b1;
    endtask

    // sender: bursts and gaps
    int burst_left = 0;
    int gap_left = 0;
    t_feed cur;

    always @(posedge i_clk) begin
        if (i_rst_n && i_in_valid && !o_in_stall) begin
            words_in++;
            decode_byte(i_in_word);
            if (cur.typed) decoded_q.push_back('{64'd0, 4'd0, cur.st, 1'b1});
            else foreach (step_q[i]) decoded_q.push_back(step_q[i]);
        end
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
        end else if (!(i_in_valid && o_in_stall)) begin
            if (gap_left > 0) begin
                gap_left--;
                i_in_valid <= 1'b0;
            end else if (feed_q.size() > 0) begin
                cur = feed_q.pop_front();
                i_in_word <= cur.w;
                i_in_valid <= 1'b1;
                if (burst_left > 0) begin
                    burst_left--;
                end else if ($urandom_range(0, 3) == 0) begin
                    burst_left = $urandom_range(20, 80);
                    gap_left = 0;
                end else begin
                    burst_left = $urandom_range(0, 6);
                    gap_left = $urandom_range(1, 5);
                end
            end else begin
                i_in_valid <= 1'b0;
            end
        end
    end

    // receiver: stall pattern, reselected at random from four kinds
    logic [15:0] stall_pat = '0;
    int cyc = 0;

    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            words_out++;
            if (decoded_q.size() == 0) begin
                $error("unexpected word: status %0d", o_out_word.status);
                errors++;
            end else begin
                t_out_word e;
                e = decoded_q.pop_front();
                if (o_out_word.out_bytes !== e.out_bytes) begin
                    $error("out_bytes: expected %h, got %h", e.out_bytes, o_out_word.out_bytes);
                    errors++;
                end
                if (o_out_word.byte_count !== e.byte_count) begin
                    $error("byte_count: expected %0d, got %0d", e.byte_count,
                           o_out_word.byte_count);
                    errors++;
                end
                if (o_out_word.status !== e.status) begin
                    $error("status: expected %0d, got %0d", e.status, o_out_word.status);
                    errors++;
                end
                if (o_out_word.run_last !== e.run_last) begin
                    $error("run_last: expected %0d, got %0d", e.run_last, o_out_word.run_last);
                    errors++;
                end
            end
        end
        if (cyc % 256 == 0) begin
            case ($urandom_range(0, 3))
                0: stall_pat = '0;
                1: stall_pat = 16'($urandom);
                2: stall_pat = 16'($urandom) | 16'($urandom);
                default: stall_pat = 16'($urandom) & 16'($urandom);
            endcase
        end
        i_out_stall <= stall_pat[cyc % 16];
        cyc++;
    end

    always @(posedge i_clk) begin
        if ((i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall)) idle_cyc = 0;
        else idle_cyc++;
        if (idle_cyc >= IdleLimit) begin
            $display("FAILURE");
            $finish;
        end
    end

    task automatic drain;
        while (feed_q.size() > 0 || i_in_valid || decoded_q.size() > 0) @(posedge i_clk);
        repeat (SettleCyc) @(posedge i_clk);
    endtask

    task automatic write_len(logic [31:0] v);
        drain();
        @(posedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_wdata <= v;
        want_len = v;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    task automatic push_byte(logic [7:0] b);
        t_feed f;
        f.w.stream_byte = b;
        f.w.stream_end = 1'b0;
        f.typed = 0;
        f.st = ST_DATA;
        feed_q.push_back(f);
    endtask

    // build one stream of mostly well-formed tokens toward the target length
    task automatic gen_stream(int unsigned target);
        int unsigned p;
        int unsigned d;
        int unsigned l;
        int unsigned room;
        int n0;
        bit quit;
        logic [7:0] f;
        logic [7:0] tok[$];
        n0 = feed_q.size();
        p = 0;
        quit = (target == 0);
        while (!quit) begin
            tok.delete();
            f = '0;
            if ($urandom_range(0, 19) == 0) begin
                f = 8'($urandom);
                repeat ($urandom_range(0, 12)) tok.push_back(8'($urandom));
                quit = 1;
            end else begin
                for (int i = 0; i < 8 && p < target; i++) begin
                    room = target - p;
                    if (p > 0 && room >= 4 && $urandom_range(0, 2) == 0) begin
                        f[i] = 1'b1;
                        if ($urandom_range(0, 1) == 1) d = $urandom_range(1, p > 4 ? 4 : p);
                        else d = $urandom_range(1, p > 65536 ? 65536 : p);
                        if ($urandom_range(0, 3) != 0) l = $urandom_range(4, room > 12 ? 12 : room);
                        else l = $urandom_range(4, room > 259 ? 259 : room);
                        if ($urandom_range(0, 29) == 0) d = p + 1;
                        if ($urandom_range(0, 29) == 0 && room < 259) l = room + 1;
                        tok.push_back(8'(d - 1));
                        tok.push_back(8'((d - 1) >> 8));
                        tok.push_back(8'(l - 4));
                        p += l;
                    end else begin
                        tok.push_back(8'($urandom));
                        p++;
                    end
                end
            end
            push_byte(f);
            foreach (tok[i]) push_byte(tok[i]);
            if (p >= target || $urandom_range(0, 14) == 0) quit = 1;
        end
        if ($urandom_range(0, 2) == 0) repeat ($urandom_range(1, 3)) push_byte(8'($urandom));
        if (feed_q.size() == n0) push_byte(8'($urandom));
        feed_q[feed_q.size()-1].w.stream_end = 1'b1;
    endtask

    initial begin
        int unsigned len;
        int unsigned target;
        t_feed f;
        plan = '{
            '{0, 0, 8'h00, 0, 1, ST_DONE},
            '{0, 0, 8'hAB, 1, 0, ST_DATA},
            '{1, 3, 8'h00, 0, 0, ST_DATA},
            '{0, 0, 8'h00, 0, 0, ST_DATA},
            '{0, 0, 8'hFF, 0, 0, ST_DATA},
            '{0, 0, 8'h00, 0, 0, ST_DATA},
            '{0, 0, 8'h5A, 0, 0, ST_DATA},
            '{0, 0, 8'h77, 1, 0, ST_DATA},
            '{0, 0, 8'h01, 0, 0, ST_DATA},
            '{0, 0, 8'h00, 0, 0, ST_DATA},
            '{0, 0, 8'h00, 0, 0, ST_DATA},
            '{0, 0, 8'h00, 0, 1, ST_BADDIST},
            '{0, 0, 8'h00, 1, 0, ST_DATA},
            '{1, 10, 8'h00, 0, 0, ST_DATA},
            '{0, 0, 8'h02, 0, 0, ST_DATA},
            '{0, 0, 8'h11, 0, 0, ST_DATA},
            '{0, 0, 8'h00, 0, 0, ST_DATA},
            '{0, 0, 8'h00, 0, 0, ST_DATA},
            '{0, 0, 8'h05, 0, 0, ST_DATA},
            '{0, 0, 8'hC3, 1, 0, ST_DATA},
            '{0, 0, 8'h02, 0, 0, ST_DATA},
            '{0, 0, 8'h22, 0, 0, ST_DATA},
            '{0, 0, 8'h00, 0, 0, ST_DATA},
            '{0, 0, 8'h00, 0, 0, ST_DATA},
            '{0, 0, 8'h06, 0, 1, ST_OVERRUN},
            '{0, 0, 8'h3C, 1, 0, ST_DATA},
            '{1, 32'hFFFF_FFFF, 8'h00, 0, 0, ST_DATA},
            '{0, 0, 8'h06, 0, 0, ST_DATA},
            '{0, 0, 8'h81, 0, 0, ST_DATA},
            '{0, 0, 8'h00, 0, 0, ST_DATA},
            '{0, 0, 8'h00, 0, 0, ST_DATA},
            '{0, 0, 8'hFF, 0, 0, ST_DATA},
            '{0, 0, 8'hFF, 0, 0, ST_DATA},
            '{0, 0, 8'hFF, 0, 0, ST_DATA},
            '{0, 0, 8'hFF, 1, 1, ST_BADDIST},
            '{0, 0, 8'h00, 0, 0, ST_DATA},
            '{0, 0, 8'h80, 1, 0, ST_DATA}
        };

        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;

        for (int r = 0; r < PlanRows; r++) begin
            if (plan[r].cfg) begin
                write_len(plan[r].val);
            end else begin
                f.w.stream_byte = plan[r].b;
                f.w.stream_end = plan[r].e;
                f.typed = plan[r].typed;
                f.st = plan[r].st;
                feed_q.push_back(f);
            end
        end

        while (words_in < 440) begin
            case ($urandom_range(0, 9))
                0: len = 0;
                1: len = 32'hFFFF_FFFF;
                2: len = $urandom_range(300, 700);
                default: len = $urandom_range(1, 80);
            endcase
            write_len(len);
            repeat ($urandom_range(1, 4)) begin
                target = (len > 2000) ? $urandom_range(10, 100) : len;
                gen_stream(target);
            end
            while (feed_q.size() > 0) @(posedge i_clk);
        end

        drain();
        $display("covered %0d input words over %0d streams, %0d output words checked",
                 words_in, streams, words_out);
        if (errors == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end
endmodule
